FILE: design/ide_tf_pkg.sv
`default_nettype none

package ide_tf_pkg;

	localparam int SECTOR_BYTES_DEF = 512;

	// Offset pipeline depth: three registered steps from the task file to the byte offset.
	localparam int CHS_LATENCY = 3;
	localparam int LAT_W = $clog2(CHS_LATENCY + 1);

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int OFFSET_W = 48;

	// Item kinds carried on the input tuser.
	typedef enum logic [1:0] {
		CMD_HOST_RD    = 2'd0,
		CMD_HOST_WR    = 2'd1,
		CMD_MEDIA_FILL = 2'd2,
		CMD_MEDIA_TAKE = 2'd3
	} item_cmd_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MASTER_CYL   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MASTER_HEADS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MASTER_SPT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_CYL    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_HEADS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_SPT    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_PRES   = 3'd6;

	// Task-file port offsets.
	localparam logic [3:0] PORT_DATA     = 4'd8;
	localparam logic [3:0] PORT_ERROR    = 4'd9;
	localparam logic [3:0] PORT_COUNT    = 4'd10;
	localparam logic [3:0] PORT_SECTOR   = 4'd11;
	localparam logic [3:0] PORT_CYL_LO   = 4'd12;
	localparam logic [3:0] PORT_CYL_HI   = 4'd13;
	localparam logic [3:0] PORT_DRV_HEAD = 4'd14;
	localparam logic [3:0] PORT_CMD_STAT = 4'd15;

	// Drive commands.
	localparam logic [7:0] ATA_READ     = 8'h20;
	localparam logic [7:0] ATA_WRITE    = 8'h30;
	localparam logic [7:0] ATA_DIAG     = 8'h90;
	localparam logic [7:0] ATA_IDENTIFY = 8'hEC;

	localparam logic [7:0] DIAG_OK       = 8'h01;
	localparam logic [7:0] DIAG_NO_SLAVE = 8'h81;

	localparam logic [7:0] STATUS_RESET = 8'h58;
	localparam int         ST_DRQ_BIT   = 3;
	localparam logic [7:0] UNUSED_PORT  = 8'hFF;

	localparam logic [1:0] MREQ_NONE  = 2'd0;
	localparam logic [1:0] MREQ_READ  = 2'd1;
	localparam logic [1:0] MREQ_WRITE = 2'd2;

	localparam int IDENT_BYTES = 14;

	typedef struct packed {
		logic [15:0] cylinder;
		logic [3:0]  head;
		logic [7:0]  sector;
		logic [4:0]  heads;
		logic [7:0]  spt;
	} chs_geo_t;

	// Byte of the identify block at a given position among its first bytes.
	function automatic logic [7:0] identify_byte(input logic [3:0] idx, input logic [15:0] cyl,
			input logic [4:0] heads, input logic [7:0] spt);
		logic [7:0] b;
		case (idx)
			4'd0: b = 8'h01;
			4'd1: b = 8'h01;
			4'd2: b = cyl[7:0];
			4'd3: b = cyl[15:8];
			4'd6: b = {3'b000, heads};
			4'd9: b = 8'h40;
			4'd11: b = 8'h02;
			4'd12: b = spt;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

FILE: design/ide_tf_sector_ram.sv
`default_nettype none

module ide_tf_sector_ram #(
	parameter int DEPTH = 512,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds until the next read, so the controller may take it late.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: design/ide_tf_chs_offset.sv
`default_nettype none

module ide_tf_chs_offset #(
	parameter int SECTOR_BYTES = 512
) (
	input  logic                                    clk,
	input  ide_tf_pkg::chs_geo_t                    geo,
	output logic signed [ide_tf_pkg::OFFSET_W-1:0] offset
);
	import ide_tf_pkg::*;

	localparam logic signed [OFFSET_W-1:0] SB_W = OFFSET_W'(SECTOR_BYTES);
	localparam logic signed [OFFSET_W-1:0] BASE = OFFSET_W'(256);

	logic [20:0]               cyl_heads;
	logic [21:0]               track_s1;
	logic [29:0]               track_spt;
	logic signed [31:0]        lba_s2;
	logic signed [OFFSET_W-1:0] lba_ext;

	// Track index, then linear sector, then bytes: one multiply per step.
	assign cyl_heads = geo.cylinder * geo.heads;
	assign track_spt = track_s1 * geo.spt;
	assign lba_ext   = {{(OFFSET_W-32){lba_s2[31]}}, lba_s2};

	always_ff @(posedge clk) begin
		track_s1 <= {1'b0, cyl_heads} + {18'd0, geo.head};
		lba_s2   <= signed'({2'b00, track_spt} + {24'd0, geo.sector} - 32'd1);
		offset   <= lba_ext * SB_W + BASE;
	end

endmodule

`default_nettype wire

FILE: design/ide_task_file_sector_buffer.sv
`default_nettype none

// Task-file register set of an IDE drive with its sector buffer.
// Items enter on the s_ channel: tuser holds the kind (host read, host write,
// media fills a byte, media takes a byte) and tdata the port offset and byte.
// Every item yields exactly one transfer on the m_ channel carrying the read
// byte, a media request code and the byte offset of the addressed sector.
// Configuration (drive geometry, slave presence) is written through the
// cfg_ port; the user writes it only while no item is in flight, which the
// block itself does not enforce; one register per write, no read-back.
// An ordinary item is accepted and touches the buffer memory, then waits
// for the registered offset multiplier chain, then loads the output register
// before the next input transfer is taken. The read and identify commands
// sweep the whole buffer, one byte per cycle, before the next item is taken.
// After reset the task file holds its power-on values and the buffer content
// is undefined until written; no clearing pass runs at reset.
// When the receiver stalls, the result waits in the output register; the
// next item is still accepted and works until its own result needs the
// register, where it waits until the old transfer completes.

module ide_task_file_sector_buffer #(
	parameter int SECTOR_BYTES = ide_tf_pkg::SECTOR_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [ide_tf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ide_tf_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [15:0]                       s_tdata,  // port_offset[3:0], write_data[11:4]
	input  logic [1:0]                        s_tuser,  // command[1:0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// read_data[7:0], media_request[9:8], media_offset[57:10]
	output logic [63:0]                       m_tdata
);
	import ide_tf_pkg::*;

	localparam int PTR_W = $clog2(SECTOR_BYTES);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SECTOR_BYTES - 1);
	localparam logic [PTR_W-1:0] PTR_IDENT_END = PTR_W'(IDENT_BYTES);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_WAIT
	} state_t;

	state_t state_q;

	// Configuration.
	logic [15:0] m_cyl_q, s_cyl_q;
	logic [4:0]  m_heads_q, s_heads_q;
	logic [7:0]  m_spt_q, s_spt_q;
	logic        slave_present_q;

	// Task file and pointers.
	logic [7:0]       status_q, error_q, count_q, sector_q;
	logic [15:0]      cylinder_q;
	logic [3:0]       head_q;
	logic             drive_q;
	logic [PTR_W-1:0] host_rd_ptr_q, host_wr_ptr_q, media_ptr_q;

	// Sequencing.
	logic [LAT_W-1:0] wait_cnt_q;
	logic [PTR_W-1:0] sweep_cnt_q;
	logic             ident_q;
	logic             use_mem_q;
	logic [7:0]       rd_imm_q;
	logic [1:0]       req_q;

	// Output register.
	logic [7:0]          out_rd_q;
	logic [1:0]          out_req_q;
	logic [OFFSET_W-1:0] out_off_q;

	item_cmd_t  cmd;
	logic [3:0] port;
	logic [7:0] wd;
	logic       accept;
	logic       load_out;

	logic [15:0] sel_cyl;
	logic [4:0]  sel_heads;
	logic [7:0]  sel_spt;

	logic             ram_we, ram_re;
	logic [PTR_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]       ram_wdata, ram_rdata, sweep_byte;
	logic [7:0]       rd_imm;

	chs_geo_t                   geo;
	logic signed [OFFSET_W-1:0] chs_off;

	logic host_rd_data, host_wr_data, host_cmd;

	assign cmd    = item_cmd_t'(s_tuser);
	assign port   = s_tdata[3:0];
	assign wd     = s_tdata[11:4];
	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;

	assign host_rd_data = (cmd == CMD_HOST_RD) && (port == PORT_DATA);
	assign host_wr_data = (cmd == CMD_HOST_WR) && (port == PORT_DATA);
	assign host_cmd     = (cmd == CMD_HOST_WR) && (port == PORT_CMD_STAT);

	// The result waits for the offset chain and for a free output register.
	assign load_out = (state_q == ST_WAIT) && (wait_cnt_q == '0) && (!m_tvalid || m_tready);

	assign sel_cyl   = drive_q ? s_cyl_q : m_cyl_q;
	assign sel_heads = drive_q ? s_heads_q : m_heads_q;
	assign sel_spt   = drive_q ? s_spt_q : m_spt_q;

	assign geo.cylinder = cylinder_q;
	assign geo.head     = head_q;
	assign geo.sector   = sector_q;
	assign geo.heads    = sel_heads;
	assign geo.spt      = sel_spt;

	// The clearing sweep writes the identify block in passing when asked to.
	assign sweep_byte = (ident_q && (sweep_cnt_q < PTR_IDENT_END)) ?
		identify_byte(sweep_cnt_q[3:0], sel_cyl, sel_heads, sel_spt) : 8'h00;

	assign m_tdata = {6'd0, out_off_q, out_req_q, out_rd_q};

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = host_wr_ptr_q;
		ram_wdata = wd;
		ram_re    = 1'b0;
		ram_raddr = host_rd_ptr_q;
		if (state_q == ST_SWEEP) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_cnt_q;
			ram_wdata = sweep_byte;
		end else if (accept) begin
			case (cmd)
				CMD_HOST_RD: ram_re = host_rd_data;
				CMD_HOST_WR: ram_we = host_wr_data;
				CMD_MEDIA_FILL: begin
					ram_we    = 1'b1;
					ram_waddr = media_ptr_q;
				end
				CMD_MEDIA_TAKE: begin
					ram_re    = 1'b1;
					ram_raddr = media_ptr_q;
				end
				default: ram_re = 1'b0;
			endcase
		end
	end

	// Byte returned from the task file itself; host writes and media fills return zero.
	always_comb begin
		rd_imm = 8'h00;
		if (cmd == CMD_HOST_RD) begin
			case (port)
				PORT_ERROR:    rd_imm = error_q;
				PORT_COUNT:    rd_imm = count_q;
				PORT_SECTOR:   rd_imm = sector_q;
				PORT_CYL_LO:   rd_imm = cylinder_q[7:0];
				PORT_CYL_HI:   rd_imm = cylinder_q[15:8];
				PORT_DRV_HEAD: rd_imm = {3'b000, drive_q, head_q};
				PORT_CMD_STAT: rd_imm = status_q;
				default:       rd_imm = UNUSED_PORT;
			endcase
		end
	end

	ide_tf_sector_ram #(
		.DEPTH(SECTOR_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ide_tf_chs_offset #(
		.SECTOR_BYTES(SECTOR_BYTES)
	) u_chs (
		.clk   (clk),
		.geo   (geo),
		.offset(chs_off)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_cyl_q         <= 16'd560;
			m_heads_q       <= 5'd6;
			m_spt_q         <= 8'd26;
			s_cyl_q         <= 16'd512;
			s_heads_q       <= 5'd1;
			s_spt_q         <= 8'd32;
			slave_present_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_MASTER_CYL:   m_cyl_q <= cfg_wr_data;
				CFG_MASTER_HEADS: m_heads_q <= cfg_wr_data[4:0];
				CFG_MASTER_SPT:   m_spt_q <= cfg_wr_data[7:0];
				CFG_SLAVE_CYL:    s_cyl_q <= cfg_wr_data;
				CFG_SLAVE_HEADS:  s_heads_q <= cfg_wr_data[4:0];
				CFG_SLAVE_SPT:    s_spt_q <= cfg_wr_data[7:0];
				CFG_SLAVE_PRES:   slave_present_q <= cfg_wr_data[0];
				default:          slave_present_q <= slave_present_q;
			endcase
		end
	end

	// Sequencer, task file and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			status_q      <= STATUS_RESET;
			error_q       <= 8'h00;
			count_q       <= 8'h01;
			sector_q      <= 8'h00;
			cylinder_q    <= 16'h0000;
			head_q        <= 4'h0;
			drive_q       <= 1'b0;
			host_rd_ptr_q <= '0;
			host_wr_ptr_q <= '0;
			media_ptr_q   <= '0;
			wait_cnt_q    <= '0;
			sweep_cnt_q   <= '0;
			ident_q       <= 1'b0;
			m_tvalid      <= 1'b0;
		end else begin
			if (load_out) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q    <= ST_WAIT;
						wait_cnt_q <= LAT_W'(CHS_LATENCY);
						case (cmd)
							CMD_HOST_RD: begin
								if (host_rd_data) begin
									if (host_rd_ptr_q == PTR_LAST) begin
										host_rd_ptr_q        <= '0;
										status_q[ST_DRQ_BIT] <= 1'b0;
									end else begin
										host_rd_ptr_q <= host_rd_ptr_q + 1'b1;
									end
								end
							end
							CMD_HOST_WR: begin
								case (port)
									PORT_DATA: begin
										if (host_wr_ptr_q == PTR_LAST) begin
											host_wr_ptr_q        <= '0;
											status_q[ST_DRQ_BIT] <= 1'b0;
											media_ptr_q          <= '0;
										end else begin
											host_wr_ptr_q <= host_wr_ptr_q + 1'b1;
										end
									end
									PORT_COUNT:  count_q <= wd;
									PORT_SECTOR: sector_q <= wd;
									PORT_CYL_LO: cylinder_q[7:0] <= wd;
									PORT_CYL_HI: cylinder_q[15:8] <= wd;
									PORT_DRV_HEAD: begin
										head_q  <= wd[3:0];
										drive_q <= wd[4];
									end
									PORT_CMD_STAT: begin
										case (wd)
											ATA_READ: begin
												status_q[ST_DRQ_BIT] <= 1'b1;
												media_ptr_q          <= '0;
												ident_q              <= 1'b0;
												sweep_cnt_q          <= '0;
												state_q              <= ST_SWEEP;
											end
											ATA_WRITE: status_q[ST_DRQ_BIT] <= 1'b1;
											ATA_DIAG: begin
												error_q <= slave_present_q ? DIAG_OK
													: DIAG_NO_SLAVE;
											end
											ATA_IDENTIFY: begin
												error_q              <= 8'h00;
												status_q[ST_DRQ_BIT] <= 1'b1;
												ident_q              <= 1'b1;
												sweep_cnt_q          <= '0;
												state_q              <= ST_SWEEP;
											end
											default: error_q <= error_q;
										endcase
									end
									default: error_q <= error_q;
								endcase
							end
							CMD_MEDIA_FILL, CMD_MEDIA_TAKE: begin
								media_ptr_q <= (media_ptr_q == PTR_LAST) ? '0
									: media_ptr_q + 1'b1;
							end
							default: error_q <= error_q;
						endcase
					end
				end
				ST_SWEEP: begin
					// The offset chain has long settled when the sweep ends.
					if (sweep_cnt_q == PTR_LAST) begin
						state_q    <= ST_WAIT;
						wait_cnt_q <= '0;
					end else begin
						sweep_cnt_q <= sweep_cnt_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (wait_cnt_q != '0) begin
						wait_cnt_q <= wait_cnt_q - 1'b1;
					end else if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Per-item result fields and the output payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			use_mem_q <= host_rd_data || (cmd == CMD_MEDIA_TAKE);
			rd_imm_q  <= rd_imm;
			if (host_wr_data && (host_wr_ptr_q == PTR_LAST)) begin
				req_q <= MREQ_WRITE;
			end else if (host_cmd && (wd == ATA_READ)) begin
				req_q <= MREQ_READ;
			end else begin
				req_q <= MREQ_NONE;
			end
		end
		if (load_out) begin
			out_rd_q  <= use_mem_q ? ram_rdata : rd_imm_q;
			out_req_q <= req_q;
			out_off_q <= chs_off;
		end
	end

	a_last_read_drops_drq: assert property (@(posedge clk) disable iff (!arst_n)
		accept && host_rd_data && (host_rd_ptr_q == PTR_LAST)
		|=> !status_q[ST_DRQ_BIT] && (host_rd_ptr_q == '0))
		else $error("last sector byte read did not clear data-request");

	a_sweep_starts_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) && $past(state_q == ST_IDLE) |-> (sweep_cnt_q == '0))
		else $error("buffer sweep did not start at the first byte");

	a_result_after_wait: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_WAIT))
		else $error("result appeared outside the wait state");

	a_clear_cmd_sets_drq: assert property (@(posedge clk) disable iff (!arst_n)
		accept && host_cmd && ((wd == ATA_READ) || (wd == ATA_IDENTIFY))
		|=> status_q[ST_DRQ_BIT] && (state_q == ST_SWEEP))
		else $error("clearing command did not start a sweep with data-request");

endmodule

`default_nettype wire
